>>> rtl/grbt_pkg.sv
// Shared types and constants of the group runtime budget table.
`timescale 1ns / 1ps
package grbt_pkg;

  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_SETLIM = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_ACTIVE = 3'd4,
    CMD_START  = 3'd5,
    CMD_CHARGE = 3'd6,
    CMD_REFILL = 3'd7
  } cmd_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_GROUP = 2'd1;
  localparam logic [1:0] ST_EXISTS   = 2'd2;

  localparam logic [6:0]  PCT_FULL     = 7'd100;
  localparam logic [31:0] PERIOD_RESET = 32'd1000000000;
  localparam logic [39:0] CREDIT_MAX   = 40'hFF_FFFF_FFFF;

  // One decoded command word as held in the front queue.
  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  gi;
    logic        gi_ok;
    logic [6:0]  qpct;
    logic [6:0]  ppct;
    logic [47:0] now;
    logic        act;
  } item_t;

  // One table entry.
  typedef struct packed {
    logic [31:0] quota;
    logic [31:0] peak;
    logic [31:0] budget;
    logic [39:0] credit;
    logic [6:0]  qpct;
    logic [6:0]  ppct;
    logic [47:0] started_at;
  } rec_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] budget;
    logic [39:0] credit;
    logic [6:0]  qpct;
    logic [6:0]  ppct;
    logic [47:0] deadline;
    logic        exhausted;
  } res_t;

endpackage

>>> rtl/grbt_front.sv
// Front end: decodes command words and queues them for the back end.
`timescale 1ns / 1ps
module grbt_front #(
  parameter int NUM_GROUPS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [2:0]            cmd,
  input  logic [3:0]            group_index,
  input  logic signed [7:0]     percent_quota,
  input  logic signed [7:0]     percent_peak,
  input  logic [47:0]           now_ns,
  input  logic                  active_flag,
  output logic                  head_valid,
  output grbt_pkg::item_t       head,
  input  logic                  head_pop
);

  grbt_pkg::item_t q_r [0:1];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  grbt_pkg::item_t dec;
  logic signed [7:0] qeff, pmax;
  logic            wr, rd;

  always_comb begin
    // quota off maps to full period; peak never below quota
    qeff = (percent_quota < 8'sd0 || percent_quota > 8'sd100) ? 8'sd100 : percent_quota;
    pmax = (percent_peak < qeff) ? qeff : percent_peak;
    if (pmax > 8'sd100) begin
      pmax = 8'sd100;
    end
    dec.cmd   = grbt_pkg::cmd_t'(cmd);
    dec.gi    = group_index;
    dec.gi_ok = ({28'd0, group_index} < 32'(NUM_GROUPS));
    dec.qpct  = qeff[6:0];
    dec.ppct  = pmax[6:0];
    dec.now   = now_ns;
    dec.act   = active_flag;
  end

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rp_r];
  assign wr         = push && !full;
  assign rd         = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        wp_r <= ~wp_r;
      end
      if (rd) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

>>> rtl/grbt_div100.sv
// Reciprocal unit: period times percent, divided by 100 over four partial products.
`timescale 1ns / 1ps
module grbt_div100 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [6:0]  b,
  output logic        done,
  output logic [31:0] q
);

  // ceil(2^46 / 100): the quotient is exact for any product below 2^39
  localparam logic [39:0] RECIP = 40'd703687441777;

  logic [38:0] num_r;
  logic [79:0] acc_r;
  logic [1:0]  cnt_r;
  logic        busy_r, done_r;
  logic [19:0] op_n, op_m;
  logic [39:0] part;
  logic [79:0] term;

  always_comb begin
    unique case (cnt_r)
      2'd0: begin
        op_n = num_r[19:0];
        op_m = RECIP[19:0];
        term = '0;
      end
      2'd1: begin
        op_n = {1'b0, num_r[38:20]};
        op_m = RECIP[19:0];
        term = '0;
      end
      2'd2: begin
        op_n = num_r[19:0];
        op_m = RECIP[39:20];
        term = '0;
      end
      2'd3: begin
        op_n = {1'b0, num_r[38:20]};
        op_m = RECIP[39:20];
        term = '0;
      end
    endcase
    part = {20'd0, op_n} * {20'd0, op_m};
    unique case (cnt_r)
      2'd0:       term = {40'd0, part};
      2'd1, 2'd2: term = {20'd0, part, 20'd0};
      2'd3:       term = {part, 40'd0};
    endcase
  end

  assign done = done_r;
  assign q    = acc_r[77:46];

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {7'd0, a} * {32'd0, b};
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + term;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + 2'd1;
      busy_r <= (cnt_r != 2'd3);
      done_r <= (cnt_r == 2'd3);
    end else begin
      done_r <= 1'b0;
    end
  end

endmodule

>>> rtl/grbt_back.sv
// Back end: group table, command sequencer, refill walk and result word.
`timescale 1ns / 1ps
module grbt_back #(
  parameter int NUM_GROUPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  input  logic             head_valid,
  input  grbt_pkg::item_t  head,
  output logic             head_pop,
  output logic             res_valid,
  output grbt_pkg::res_t   res,
  output logic [10:0]      sum_out,
  input  logic             res_pop
);

  localparam int DEPTH = (NUM_GROUPS < 16) ? NUM_GROUPS : 16;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DIVQ, S_DIVP, S_SL_FIN, S_REF_RD, S_REF_UPD, S_REF_FIN, S_REF_OUT
  } state_t;

  state_t          state_r;
  grbt_pkg::item_t cur_r;
  grbt_pkg::rec_t  rec_r;
  grbt_pkg::rec_t  mem [0:DEPTH-1];
  grbt_pkg::rec_t  rdata_r;
  logic [IW-1:0]   ref_i_r;
  logic [DEPTH-1:0] exists_r, active_r;
  logic [10:0]     sum_r;
  logic [31:0]     period_r, quota_new_r;
  logic            res_valid_r;
  grbt_pkg::res_t  res_r;

  logic [IW-1:0]   idx_cur, rd_idx, wr_idx;
  logic            ex_cur, wr_en;
  grbt_pkg::rec_t  wr_data, rec_create, rec_start, rec_charge, rec_refill, rec_setlim;
  logic [47:0]     used, deadline;
  logic [31:0]     consumed;
  logic            div_start, div_done;
  logic [31:0]     div_q;
  logic [6:0]      div_b;

  grbt_div100 u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (period_r),
    .b     (div_b),
    .done  (div_done),
    .q     (div_q)
  );

  function automatic grbt_pkg::res_t mk_res(logic [1:0] st, logic ex, grbt_pkg::rec_t r,
                                             logic [47:0] dl);
    grbt_pkg::res_t o;
    o.status    = st;
    o.budget    = ex ? r.budget : 32'd0;
    o.credit    = ex ? r.credit : 40'd0;
    o.qpct      = ex ? r.qpct : 7'd0;
    o.ppct      = ex ? r.ppct : 7'd0;
    o.deadline  = dl;
    o.exhausted = ex && (r.budget == 32'd0);
    return o;
  endfunction

  function automatic grbt_pkg::rec_t refill(grbt_pkg::rec_t r, logic act);
    grbt_pkg::rec_t o;
    logic [32:0] s;
    logic [40:0] c;
    logic [31:0] need;
    logic [39:0] take;
    o    = r;
    s    = {1'b0, r.budget} + {1'b0, r.quota};
    c    = {1'b0, r.credit} + {8'd0, s - {1'b0, r.peak}};
    need = r.peak - s[31:0];
    take = (r.credit < {8'd0, need}) ? r.credit : {8'd0, need};
    if (r.quota == r.peak) begin
      o.budget = r.quota;
    end else if (!act) begin
      o.credit = 40'd0;
      o.budget = r.quota;
    end else if (s > {1'b0, r.peak}) begin
      // excess over peak goes into credit
      o.credit = c[40] ? grbt_pkg::CREDIT_MAX : c[39:0];
      o.budget = r.peak;
    end else begin
      // pay credit back up to peak
      o.credit = r.credit - take;
      o.budget = s[31:0] + take[31:0];
    end
    return o;
  endfunction

  always_comb begin
    idx_cur  = cur_r.gi[IW-1:0];
    ex_cur   = cur_r.gi_ok && exists_r[idx_cur];
    head_pop = (state_r == S_IDLE) && head_valid && !res_valid_r;

    rec_create           = rdata_r;
    rec_create.quota     = period_r;
    rec_create.peak      = period_r;
    rec_create.budget    = period_r;
    rec_create.credit    = 40'd0;
    rec_create.qpct      = grbt_pkg::PCT_FULL;
    rec_create.ppct      = grbt_pkg::PCT_FULL;

    rec_start            = rdata_r;
    rec_start.started_at = cur_r.now;
    deadline             = cur_r.now + {16'd0, rdata_r.budget};

    used                 = cur_r.now - rdata_r.started_at;
    rec_charge           = rdata_r;
    rec_charge.budget    = (used < {16'd0, rdata_r.budget}) ?
                           rdata_r.budget - used[31:0] : 32'd0;

    rec_refill           = refill(rdata_r, active_r[ref_i_r]);

    // carry consumed time over to the new quota
    consumed             = (rec_r.budget <= rec_r.quota) ? rec_r.quota - rec_r.budget : 32'd0;
    rec_setlim           = rec_r;
    rec_setlim.quota     = quota_new_r;
    rec_setlim.peak      = div_q;
    rec_setlim.budget    = (quota_new_r >= consumed) ? quota_new_r - consumed : 32'd0;
    rec_setlim.credit    = 40'd0;
    rec_setlim.qpct      = cur_r.qpct;
    rec_setlim.ppct      = cur_r.ppct;

    unique case (state_r)
      S_IDLE:    rd_idx = head.gi[IW-1:0];
      S_REF_RD:  rd_idx = ref_i_r;
      default:   rd_idx = idx_cur;
    endcase

    wr_en   = 1'b0;
    wr_idx  = idx_cur;
    wr_data = rec_create;
    unique case (state_r)
      S_EXEC: begin
        unique case (cur_r.cmd)
          grbt_pkg::CMD_CREATE: wr_en = cur_r.gi_ok && !ex_cur;
          grbt_pkg::CMD_START: begin
            wr_en   = ex_cur;
            wr_data = rec_start;
          end
          grbt_pkg::CMD_CHARGE: begin
            wr_en   = ex_cur;
            wr_data = rec_charge;
          end
          default: wr_en = 1'b0;
        endcase
      end
      S_REF_UPD: begin
        wr_en   = exists_r[ref_i_r];
        wr_idx  = ref_i_r;
        wr_data = rec_refill;
      end
      S_SL_FIN: begin
        wr_en   = 1'b1;
        wr_data = rec_setlim;
      end
      default: wr_en = 1'b0;
    endcase

    div_start = 1'b0;
    div_b     = cur_r.qpct;
    if (state_r == S_EXEC && cur_r.cmd == grbt_pkg::CMD_SETLIM && ex_cur) begin
      div_start = 1'b1;
    end else if (state_r == S_DIVQ && div_done) begin
      div_start = 1'b1;
      div_b     = cur_r.ppct;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_idx];
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign sum_out   = sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exists_r    <= '0;
      active_r    <= '0;
      sum_r       <= 11'd0;
      period_r    <= grbt_pkg::PERIOD_RESET;
      res_valid_r <= 1'b0;
      ref_i_r     <= '0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      if (res_pop && res_valid_r) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (head_pop) begin
            cur_r   <= head;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r     <= S_IDLE;
          res_valid_r <= 1'b1;
          if (cur_r.cmd == grbt_pkg::CMD_REFILL) begin
            res_valid_r <= 1'b0;
            ref_i_r     <= '0;
            state_r     <= S_REF_RD;
          end else if (cur_r.cmd == grbt_pkg::CMD_CREATE) begin
            if (!cur_r.gi_ok) begin
              res_r <= mk_res(grbt_pkg::ST_NO_GROUP, 1'b0, rdata_r, 48'd0);
            end else if (ex_cur) begin
              res_r <= mk_res(grbt_pkg::ST_EXISTS, 1'b1, rdata_r, 48'd0);
            end else begin
              exists_r[idx_cur] <= 1'b1;
              active_r[idx_cur] <= 1'b0;
              sum_r             <= sum_r + 11'd100;
              res_r <= mk_res(grbt_pkg::ST_OK, 1'b1, rec_create, 48'd0);
            end
          end else if (!ex_cur) begin
            res_r <= mk_res(grbt_pkg::ST_NO_GROUP, 1'b0, rdata_r, 48'd0);
          end else begin
            unique case (cur_r.cmd)
              grbt_pkg::CMD_REMOVE: begin
                exists_r[idx_cur] <= 1'b0;
                active_r[idx_cur] <= 1'b0;
                sum_r             <= sum_r - {4'd0, rdata_r.qpct};
                res_r <= mk_res(grbt_pkg::ST_OK, 1'b0, rdata_r, 48'd0);
              end
              grbt_pkg::CMD_SETLIM: begin
                rec_r       <= rdata_r;
                res_valid_r <= 1'b0;
                state_r     <= S_DIVQ;
              end
              grbt_pkg::CMD_ACTIVE: begin
                active_r[idx_cur] <= cur_r.act;
                res_r <= mk_res(grbt_pkg::ST_OK, 1'b1, rdata_r, 48'd0);
              end
              grbt_pkg::CMD_START:
                res_r <= mk_res(grbt_pkg::ST_OK, 1'b1, rec_start, deadline);
              grbt_pkg::CMD_CHARGE:
                res_r <= mk_res(grbt_pkg::ST_OK, 1'b1, rec_charge, 48'd0);
              default:
                res_r <= mk_res(grbt_pkg::ST_OK, 1'b1, rdata_r, 48'd0);
            endcase
          end
        end
        S_DIVQ: begin
          if (div_done) begin
            quota_new_r <= div_q;
            state_r     <= S_DIVP;
          end
        end
        S_DIVP: begin
          if (div_done) begin
            state_r <= S_SL_FIN;
          end
        end
        S_SL_FIN: begin
          sum_r       <= sum_r - {4'd0, rec_r.qpct} + {4'd0, cur_r.qpct};
          res_r       <= mk_res(grbt_pkg::ST_OK, 1'b1, rec_setlim, 48'd0);
          res_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_REF_RD: state_r <= S_REF_UPD;
        S_REF_UPD: begin
          if (ref_i_r == IW'(DEPTH - 1)) begin
            state_r <= S_REF_FIN;
          end else begin
            ref_i_r <= ref_i_r + IW'(1);
            state_r <= S_REF_RD;
          end
        end
        S_REF_FIN: state_r <= S_REF_OUT;
        S_REF_OUT: begin
          res_r       <= mk_res(grbt_pkg::ST_OK, ex_cur, rdata_r, 48'd0);
          res_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/group_runtime_budget_table.sv
// Top level of the group runtime budget table.
`timescale 1ns / 1ps
// Command words enter through a two-word queue (push/full) and results leave
// through a one-word output register (empty/pop). Most commands pass from the
// head of the queue to a result through the state that takes the word and an
// execute state. Set limit uses one unit that forms period * percent / 100 by
// a reciprocal multiplication in four partial products, twice; a refill tick
// walks the table entry by entry, with a read and an update state for each.
// A new command starts only once the previous result has been popped.
// The table needs no clearing pass after reset.
module group_runtime_budget_table #(
  parameter int NUM_GROUPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_period_ns,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        in_cmd,
  input  logic [3:0]        in_group_index,
  input  logic signed [7:0] in_percent_quota,
  input  logic signed [7:0] in_percent_peak,
  input  logic [47:0]       in_now_ns,
  input  logic              in_active_flag,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        out_status,
  output logic [31:0]       out_budget_left,
  output logic [39:0]       out_credit_held,
  output logic [6:0]        out_quota_percent_out,
  output logic [6:0]        out_peak_percent_out,
  output logic [10:0]       out_percent_sum,
  output logic [47:0]       out_deadline_ns,
  output logic              out_exhausted
);

  logic            head_valid, head_pop, res_valid;
  grbt_pkg::item_t head;
  grbt_pkg::res_t  res;

  grbt_front #(.NUM_GROUPS(NUM_GROUPS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .cmd           (in_cmd),
    .group_index   (in_group_index),
    .percent_quota (in_percent_quota),
    .percent_peak  (in_percent_peak),
    .now_ns        (in_now_ns),
    .active_flag   (in_active_flag),
    .head_valid    (head_valid),
    .head          (head),
    .head_pop      (head_pop)
  );

  grbt_back #(.NUM_GROUPS(NUM_GROUPS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_period_ns),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .res_valid  (res_valid),
    .res        (res),
    .sum_out    (out_percent_sum),
    .res_pop    (pop)
  );

  assign empty                 = !res_valid;
  assign out_status            = res.status;
  assign out_budget_left       = res.budget;
  assign out_credit_held       = res.credit;
  assign out_quota_percent_out = res.qpct;
  assign out_peak_percent_out  = res.ppct;
  assign out_deadline_ns       = res.deadline;
  assign out_exhausted         = res.exhausted;

endmodule

>>> tb/tb_group_runtime_budget_table.sv
// Self-checking bench for the group runtime budget table: random commands vs. a local model.
`timescale 1ns / 1ps
module tb_group_runtime_budget_table;

  localparam int NG = 16;
  localparam longint LIMIT = 1200000;

  typedef struct {
    grbt_pkg::cmd_t  cmd;
    logic [3:0]      gi;
    logic signed [7:0] qp;
    logic signed [7:0] pp;
    logic [47:0]     now;
    logic            act;
  } cmd_word_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] budget;
    logic [39:0] credit;
    logic [6:0]  qpct;
    logic [6:0]  ppct;
    logic [10:0] psum;
    logic [47:0] deadline;
    logic        exh;
  } answer_t;

  logic clk, rst_n, cfg_we, push, full, empty, pop;
  logic [31:0] cfg_period_ns;
  logic [2:0] in_cmd;
  logic [3:0] in_group_index;
  logic signed [7:0] in_percent_quota, in_percent_peak;
  logic [47:0] in_now_ns;
  logic in_active_flag;
  logic [1:0] out_status;
  logic [31:0] out_budget_left;
  logic [39:0] out_credit_held;
  logic [6:0] out_quota_percent_out, out_peak_percent_out;
  logic [10:0] out_percent_sum;
  logic [47:0] out_deadline_ns;
  logic out_exhausted;

  group_runtime_budget_table #(.NUM_GROUPS(NG)) DUT (.*);

  // model state
  logic [31:0] m_period;
  logic        m_exists [NG];
  logic        m_active [NG];
  logic        m_started [NG];
  logic [31:0] m_quota [NG], m_peak [NG], m_budget [NG];
  logic [39:0] m_credit [NG];
  logic [6:0]  m_qpct [NG], m_ppct [NG];
  logic [47:0] m_start [NG];
  logic [47:0] clock_ns [NG];

  cmd_word_t pending_words[$];
  answer_t   expected_answers[$];
  int errors = 0;
  longint cycles = 0;
  bit stim_done = 0;
  int rx_cycles = 0;

  function automatic logic [31:0] share_of_period(int pct);
    logic [63:0] p;
    p = 64'(m_period) * 64'(pct) / 64'd100;
    return p[31:0];
  endfunction

  function automatic void refill_group(int g);
    logic [32:0] s;
    logic [40:0] c;
    logic [39:0] take;
    if (m_quota[g] == m_peak[g]) begin
      m_budget[g] = m_quota[g];
    end else if (!m_active[g]) begin
      m_credit[g] = '0;
      m_budget[g] = m_quota[g];
    end else begin
      s = 33'(m_budget[g]) + 33'(m_quota[g]);
      if (s > 33'(m_peak[g])) begin
        c = 41'(m_credit[g]) + 41'(s - 33'(m_peak[g]));
        m_credit[g] = c > 41'(grbt_pkg::CREDIT_MAX) ? grbt_pkg::CREDIT_MAX : c[39:0];
        m_budget[g] = m_peak[g];
      end else begin
        take = 40'(33'(m_peak[g]) - s);
        if (m_credit[g] < take) take = m_credit[g];
        m_credit[g] = m_credit[g] - take;
        m_budget[g] = 32'(s + 33'(take));
      end
    end
  endfunction

  function automatic answer_t budget_table_step(cmd_word_t w);
    answer_t a;
    int g, qp, pp, sum;
    logic ex;
    logic [31:0] oldq, used32;
    logic [47:0] used;
    g = w.gi;
    ex = m_exists[g];
    a.status = grbt_pkg::ST_OK;
    a.deadline = '0;
    case (w.cmd)
      grbt_pkg::CMD_REFILL: begin
        for (int i = 0; i < NG; i++) if (m_exists[i]) refill_group(i);
      end
      grbt_pkg::CMD_CREATE: begin
        if (ex) a.status = grbt_pkg::ST_EXISTS;
        else begin
          m_exists[g] = 1; m_active[g] = 0;
          m_quota[g] = m_period; m_peak[g] = m_period; m_budget[g] = m_period;
          m_credit[g] = '0; m_qpct[g] = grbt_pkg::PCT_FULL; m_ppct[g] = grbt_pkg::PCT_FULL;
          ex = 1;
        end
      end
      default: begin
        if (!ex) a.status = grbt_pkg::ST_NO_GROUP;
        else case (w.cmd)
          grbt_pkg::CMD_REMOVE: begin
            m_exists[g] = 0; m_active[g] = 0; ex = 0;
          end
          grbt_pkg::CMD_SETLIM: begin
            qp = int'(w.qp); pp = int'(w.pp);
            oldq = m_quota[g];
            if (qp < 0 || qp > 100) begin
              qp = 100; m_quota[g] = m_period;
            end else m_quota[g] = share_of_period(qp);
            if (pp < qp) pp = qp;
            if (pp > 100) begin
              pp = 100; m_peak[g] = m_period;
            end else m_peak[g] = share_of_period(pp);
            m_qpct[g] = 7'(qp); m_ppct[g] = 7'(pp);
            used32 = m_budget[g] <= oldq ? oldq - m_budget[g] : 32'd0;
            m_budget[g] = m_quota[g] >= used32 ? m_quota[g] - used32 : 32'd0;
            m_credit[g] = '0;
          end
          grbt_pkg::CMD_ACTIVE: m_active[g] = w.act;
          grbt_pkg::CMD_START: begin
            m_start[g] = w.now;
            a.deadline = w.now + 48'(m_budget[g]);
          end
          grbt_pkg::CMD_CHARGE: begin
            used = w.now - m_start[g];
            if (used < 48'(m_budget[g])) m_budget[g] = m_budget[g] - used[31:0];
            else m_budget[g] = '0;
          end
          default: ;
        endcase
      end
    endcase
    a.budget = ex ? m_budget[g] : '0;
    a.credit = ex ? m_credit[g] : '0;
    a.qpct = ex ? m_qpct[g] : '0;
    a.ppct = ex ? m_ppct[g] : '0;
    a.exh = ex && m_budget[g] == 0;
    sum = 0;
    for (int i = 0; i < NG; i++) if (m_exists[i]) sum += m_qpct[i];
    a.psum = sum > 2047 ? 11'd2047 : 11'(sum);
    return a;
  endfunction

  // Queue a word; charges to a never-started group are turned into start runs.
  task automatic queue_word(grbt_pkg::cmd_t c, int g, int qp, int pp, logic [47:0] now,
                            logic act);
    cmd_word_t w;
    w.cmd = c; w.gi = 4'(g); w.qp = 8'(qp); w.pp = 8'(pp); w.now = now; w.act = act;
    if (c == grbt_pkg::CMD_CREATE && !m_exists[g]) m_started[g] = 0;
    if (c == grbt_pkg::CMD_CHARGE && m_exists[g] && !m_started[g]) w.cmd = grbt_pkg::CMD_START;
    if (w.cmd == grbt_pkg::CMD_START && m_exists[g]) m_started[g] = 1;
    pending_words.push_back(w);
    expected_answers.push_back(budget_table_step(w));
  endtask

  task automatic drain_and_write(logic [31:0] p);
    while (pending_words.size() != 0 || expected_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1; cfg_period_ns <= p;
    @(negedge clk);
    cfg_we <= 0;
    m_period = p;
  endtask

  task automatic random_phase(int n);
    int g, c, r;
    logic [47:0] t;
    for (int k = 0; k < n; k++) begin
      g = $urandom_range(0, NG - 1);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // well-formed session on a group: live time stamps
        c = $urandom_range(0, 6);
        if (c == 0 && m_exists[g]) c = $urandom_range(2, 6);
        if (c == 1 && $urandom_range(0, 3) != 0) c = 6;
      end else c = $urandom_range(0, 7);
      if (r % 13 == 0) c = grbt_pkg::CMD_REFILL;
      if (c == grbt_pkg::CMD_START || c == grbt_pkg::CMD_CHARGE) begin
        if ($urandom_range(0, 19) == 0) t = {$urandom, $urandom}; // jump, may run backwards
        else t = clock_ns[g] + 48'($urandom_range(0, m_period > 4000 ? 2 * m_period[31:2] : 8000));
        clock_ns[g] = t;
      end else t = {$urandom, $urandom};
      queue_word(grbt_pkg::cmd_t'(c), g,
                 $urandom_range(0, 3) == 0 ? int'($signed(8'($urandom))) : $urandom_range(0, 100),
                 $urandom_range(0, 3) == 0 ? int'($signed(8'($urandom))) : $urandom_range(0, 100),
                 t, 1'($urandom));
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 0; cfg_we = 0; cfg_period_ns = '0;
    m_period = grbt_pkg::PERIOD_RESET;
    for (int i = 0; i < NG; i++) begin
      m_exists[i] = 0; m_active[i] = 0; m_started[i] = 0;
      m_quota[i] = '0; m_peak[i] = '0; m_budget[i] = '0; m_credit[i] = '0;
      m_qpct[i] = '0; m_ppct[i] = '0; m_start[i] = '0; clock_ns[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // directed: errors on missing groups, duplicates, percent extremes, refill modes
    queue_word(grbt_pkg::CMD_QUERY, 3, 0, 0, '0, 0);
    queue_word(grbt_pkg::CMD_CHARGE, 15, 0, 0, '1, 1);
    queue_word(grbt_pkg::CMD_CREATE, 0, 0, 0, '0, 0);
    queue_word(grbt_pkg::CMD_CREATE, 0, 0, 0, '0, 0);
    queue_word(grbt_pkg::CMD_CREATE, 15, 0, 0, '0, 0);
    queue_word(grbt_pkg::CMD_SETLIM, 0, 127, -128, '0, 0);
    queue_word(grbt_pkg::CMD_SETLIM, 0, 30, 10, '0, 0);
    queue_word(grbt_pkg::CMD_SETLIM, 15, 0, 127, '0, 0);
    queue_word(grbt_pkg::CMD_SETLIM, 15, 40, 100, '0, 0);
    queue_word(grbt_pkg::CMD_ACTIVE, 15, 0, 0, '0, 1);
    queue_word(grbt_pkg::CMD_START, 15, 0, 0, 48'hFFFF_FFFF_FF00, 0);
    queue_word(grbt_pkg::CMD_CHARGE, 15, 0, 0, 48'h0000_0000_0100, 0);
    queue_word(grbt_pkg::CMD_START, 15, 0, 0, 48'd1000, 0);
    queue_word(grbt_pkg::CMD_CHARGE, 15, 0, 0, 48'd999, 0);
    queue_word(grbt_pkg::CMD_START, 15, 0, 0, 48'd5000, 0);
    queue_word(grbt_pkg::CMD_REFILL, 0, 0, 0, '0, 0);
    queue_word(grbt_pkg::CMD_REFILL, 0, 0, 0, '0, 0);
    queue_word(grbt_pkg::CMD_REFILL, 0, 0, 0, '0, 0);
    queue_word(grbt_pkg::CMD_START, 15, 0, 0, 48'd7000, 0);
    queue_word(grbt_pkg::CMD_CHARGE, 15, 0, 0, 48'd7100, 0);
    queue_word(grbt_pkg::CMD_ACTIVE, 15, 0, 0, '0, 0);
    queue_word(grbt_pkg::CMD_REFILL, 0, 0, 0, '0, 0);
    queue_word(grbt_pkg::CMD_REMOVE, 15, 0, 0, '0, 0);
    queue_word(grbt_pkg::CMD_REMOVE, 15, 0, 0, '0, 0);
    random_phase(250);
    drain_and_write(32'd1);
    random_phase(150);
    drain_and_write(32'hFFFF_FFFF);
    // active groups with high quota and low budget draw heavy credit
    random_phase(250);
    drain_and_write(32'd3000);
    random_phase(200);
    drain_and_write(grbt_pkg::PERIOD_RESET);
    random_phase(180);
    while (pending_words.size() != 0) @(posedge clk);
    stim_done = 1;
  end

  // record whether the word on the input was taken at this edge
  bit in_took = 0;
  always @(posedge clk) in_took = rst_n && push && !full;

  // driver: bursts with gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 0;
    end else begin
      if (in_took && pending_words.size() != 0) void'(pending_words.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        push <= 0;
      end else if (pending_words.size() != 0) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
        end
        if (in_took) burst_left--;
        if (burst_left == 0 && $urandom_range(0, 1)) gap_left = $urandom_range(1, 40);
        push <= pending_words.size() != 0;
        in_cmd <= pending_words.size() != 0 ? pending_words[0].cmd : 3'd0;
        in_group_index <= pending_words.size() != 0 ? pending_words[0].gi : 4'd0;
        in_percent_quota <= pending_words.size() != 0 ? pending_words[0].qp : 8'sd0;
        in_percent_peak <= pending_words.size() != 0 ? pending_words[0].pp : 8'sd0;
        in_now_ns <= pending_words.size() != 0 ? pending_words[0].now : 48'd0;
        in_active_flag <= pending_words.size() != 0 ? pending_words[0].act : 1'b0;
      end else push <= 0;
    end
  end

  initial begin
    push = 0; in_cmd = '0; in_group_index = '0; in_percent_quota = '0;
    in_percent_peak = '0; in_now_ns = '0; in_active_flag = 0; pop = 0;
  end

  // receiver stall pattern, with one long hold-off early on
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 0;
    end else begin
      rx_cycles++;
      if (rx_cycles > 400 && rx_cycles < 3400) begin
        pop <= 0;
      end else begin
        case (($urandom_range(0, 15) + rx_cycles / 1024) % 4)
          0: pop <= $urandom_range(0, 9) == 0;
          default: pop <= 1;
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t e;
    cycles++;
    if (rst_n && pop && !empty) begin
      if (expected_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected word exp none got status=%0d", $time, out_status);
      end else begin
        e = expected_answers.pop_front();
        if (out_status !== e.status) begin
          errors++; $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
        end
        if (out_budget_left !== e.budget) begin
          errors++; $display("%0t: budget exp %0d got %0d", $time, e.budget, out_budget_left);
        end
        if (out_credit_held !== e.credit) begin
          errors++; $display("%0t: credit exp %0d got %0d", $time, e.credit, out_credit_held);
        end
        if (out_quota_percent_out !== e.qpct) begin
          errors++;
          $display("%0t: quota pct exp %0d got %0d", $time, e.qpct, out_quota_percent_out);
        end
        if (out_peak_percent_out !== e.ppct) begin
          errors++;
          $display("%0t: peak pct exp %0d got %0d", $time, e.ppct, out_peak_percent_out);
        end
        if (out_percent_sum !== e.psum) begin
          errors++; $display("%0t: pct sum exp %0d got %0d", $time, e.psum, out_percent_sum);
        end
        if (out_deadline_ns !== e.deadline) begin
          errors++;
          $display("%0t: deadline exp %0h got %0h", $time, e.deadline, out_deadline_ns);
        end
        if (out_exhausted !== e.exh) begin
          errors++; $display("%0t: exhausted exp %0b got %0b", $time, e.exh, out_exhausted);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_answers.size() != 0 && cycles < LIMIT) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0)
      $display("tb_group_runtime_budget_table OK");
    else
      $display("tb_group_runtime_budget_table NOT OK");
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("tb_group_runtime_budget_table NOT OK");
    $finish;
  end

endmodule

>>> files.f
rtl/grbt_pkg.sv
rtl/grbt_front.sv
rtl/grbt_div100.sv
rtl/grbt_back.sv
rtl/group_runtime_budget_table.sv
tb/tb_group_runtime_budget_table.sv
